/* sv/mbrtu_pkg.sv */
// Shared constants, types and the CRC-16 update function of the Modbus RTU slave.
package mbrtu_pkg;

  localparam int MAX_FRAME      = 64;
  localparam int PARAM_DEPTH    = 2048;
  localparam int DRIVE_DEPTH    = 256;
  localparam int MAX_READ_WORDS = 16;

  localparam int FS_AW     = $clog2(MAX_FRAME);
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int PA_AW     = $clog2(PARAM_DEPTH);
  localparam int DA_AW     = $clog2(DRIVE_DEPTH);
  localparam int CLR_DEPTH = (PARAM_DEPTH > DRIVE_DEPTH) ? PARAM_DEPTH : DRIVE_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int RPL_MAX   = 5 + 2 * MAX_READ_WORDS;
  localparam int RPL_W     = $clog2(RPL_MAX + 1);
  localparam int WC_W      = 8;
  localparam int WA_W      = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] PARAM_LIMIT = 16'h0800;
  localparam logic [15:0] DRIVE_BASE  = 16'd5000;
  localparam logic [15:0] WRITE_LIMIT = 16'd6000;
  localparam logic [7:0]  MULTI_LIMIT = 8'd100;
  localparam int          MIN_FRAME   = 8;

  localparam logic [7:0] FN_READ        = 8'd3;
  localparam logic [7:0] FN_WRITE_ONE   = 8'd6;
  localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_EN  = 2'd2;

  typedef enum logic [2:0] {
    JOB_READ     = 3'b001,
    JOB_WR_ONE   = 3'b010,
    JOB_WR_MULTI = 3'b100
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [CNT_W-1:0] n;
    logic [7:0]       fn;
    logic [15:0]      addr;
    logic [7:0]       b4;
    logic [7:0]       b5;
  } job_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] silence;
    logic       read_en;
  } cfg_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    end
    return x;
  endfunction

endpackage

/* sv/mbrtu_ifs.sv */
// Valid/ready channel interfaces for the input, result and configuration ports.
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, opcode, rx_byte, input ready);
  modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

interface mbrtu_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mbrtu_pkg::CFG_IDX_W-1:0]     index;
  logic [7:0]                          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/mbrtu_front.sv */
// Front part: frame collection, silence timing, CRC check and job classification.
module mbrtu_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbrtu_pkg::cfg_t              cfg,
  input  logic                         can_take,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [7:0]                   in_rx_byte,
  output logic                         push,
  output mbrtu_pkg::job_t              push_job,
  input  logic [mbrtu_pkg::FS_AW-1:0]  fs_raddr,
  output logic [7:0]                   fs_rdata
);

  logic [7:0] fs_mem [mbrtu_pkg::MAX_FRAME];

  logic [mbrtu_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [7:0]                  idle_r, idle_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [7:0]                  b0_r, b0_nxt, fn_r, fn_nxt, ahi_r, ahi_nxt, alo_r, alo_nxt;
  logic [7:0]                  b4_r, b4_nxt, b5_r, b5_nxt;
  logic                        acc, fs_we, frame_ok;

  assign in_ready = can_take;
  assign acc      = in_valid && can_take;

  // The CRC run over the whole frame, check bytes included, is zero for a good frame.
  assign frame_ok = !ovf_r && (count_r >= mbrtu_pkg::CNT_W'(mbrtu_pkg::MIN_FRAME)) &&
                    (b0_r == cfg.dev_addr) && (crc_r == 16'h0000);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    idle_nxt  = idle_r;
    crc_nxt   = crc_r;
    b0_nxt    = b0_r;
    fn_nxt    = fn_r;
    ahi_nxt   = ahi_r;
    alo_nxt   = alo_r;
    b4_nxt    = b4_r;
    b5_nxt    = b5_r;
    fs_we     = 1'b0;
    push      = 1'b0;
    push_job  = '{kind: mbrtu_pkg::JOB_READ, n: count_r, fn: fn_r,
                  addr: {ahi_r, alo_r}, b4: b4_r, b5: b5_r};
    if (acc) begin
      if (in_opcode == mbrtu_pkg::OP_BYTE) begin
        idle_nxt = 8'd0;
        if (count_r < mbrtu_pkg::CNT_W'(mbrtu_pkg::MAX_FRAME)) begin
          fs_we     = 1'b1;
          count_nxt = count_r + 1'b1;
          crc_nxt   = mbrtu_pkg::crc_upd(crc_r, in_rx_byte);
          case (count_r)
            mbrtu_pkg::CNT_W'(0): b0_nxt  = in_rx_byte;
            mbrtu_pkg::CNT_W'(1): fn_nxt  = in_rx_byte;
            mbrtu_pkg::CNT_W'(2): ahi_nxt = in_rx_byte;
            mbrtu_pkg::CNT_W'(3): alo_nxt = in_rx_byte;
            mbrtu_pkg::CNT_W'(4): b4_nxt  = in_rx_byte;
            mbrtu_pkg::CNT_W'(5): b5_nxt  = in_rx_byte;
            default: ;
          endcase
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (count_r != '0) begin
        if (idle_r < cfg.silence) begin
          idle_nxt = idle_r + 8'd1;
        end else begin
          idle_nxt  = 8'd0;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          crc_nxt   = 16'hFFFF;
          unique case (fn_r)
            mbrtu_pkg::FN_READ: begin
              push_job.kind = mbrtu_pkg::JOB_READ;
              push          = frame_ok;
            end
            mbrtu_pkg::FN_WRITE_ONE: begin
              push_job.kind = mbrtu_pkg::JOB_WR_ONE;
              push          = frame_ok;
            end
            mbrtu_pkg::FN_WRITE_MULTI: begin
              push_job.kind = mbrtu_pkg::JOB_WR_MULTI;
              push          = frame_ok;
            end
            default: push = 1'b0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      idle_r  <= 8'd0;
      crc_r   <= 16'hFFFF;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      idle_r  <= idle_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r  <= b0_nxt;
    fn_r  <= fn_nxt;
    ahi_r <= ahi_nxt;
    alo_r <= alo_nxt;
    b4_r  <= b4_nxt;
    b5_r  <= b5_nxt;
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[count_r[mbrtu_pkg::FS_AW-1:0]] <= in_rx_byte;
    end
    fs_rdata <= fs_mem[fs_raddr];
  end

endmodule

/* sv/mbrtu_jobq.sv */
// Two-entry job queue between the front and back parts.
module mbrtu_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbrtu_pkg::job_t push_job,
  input  logic            pop,
  output logic            nonempty,
  output mbrtu_pkg::job_t head
);

  mbrtu_pkg::job_t ent_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign nonempty = (cnt_r != 2'd0);
  assign head     = ent_r[rp_r];
  assign do_push  = push && (cnt_r != 2'd2);
  assign do_pop   = pop && nonempty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

/* sv/mbrtu_back.sv */
// Back part: table clearing, register reads and writes, and reply byte emission.
module mbrtu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbrtu_pkg::cfg_t              cfg,
  input  logic                         job_valid,
  input  mbrtu_pkg::job_t              job,
  output logic                         job_pop,
  output logic                         idle,
  output logic [mbrtu_pkg::FS_AW-1:0]  fs_raddr,
  input  logic [7:0]                   fs_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_tx_byte,
  output logic                         out_last_byte
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_WR_ONE = 9'b000000100,
    S_WR_A   = 9'b000001000,
    S_WR_B   = 9'b000010000,
    S_WR_C   = 9'b000100000,
    S_FETCH  = 9'b001000000,
    S_WAIT   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } back_state_t;

  localparam int WA_W = mbrtu_pkg::WA_W;

  logic [15:0] param_mem [mbrtu_pkg::PARAM_DEPTH];
  logic [15:0] drive_mem [mbrtu_pkg::DRIVE_DEPTH];
  logic [15:0] param_q, drive_q;

  back_state_t                  st_r, st_nxt;
  logic [mbrtu_pkg::CLR_W-1:0]  clr_r, clr_nxt;
  mbrtu_pkg::job_kind_t         kind_r, kind_nxt;
  logic [7:0]                   fn_r, fn_nxt, b4_r, b4_nxt, b5_r, b5_nxt, hi_r, hi_nxt;
  logic [15:0]                  addr_r, addr_nxt, crc_r, crc_nxt, word_r, word_nxt;
  logic [WA_W-1:0]              wa_r, wa_nxt, drive_off;
  logic [mbrtu_pkg::WC_W-1:0]   k_r, k_nxt, words_r, words_nxt, words_ld, avail;
  logic [mbrtu_pkg::RPL_W-1:0]  idx_r, idx_nxt, len_r, len_nxt;
  logic                         allowed_r, allowed_nxt, have_r, have_nxt;
  logic                         selp_r, selp_nxt, seld_r, seld_nxt;
  logic                         ov_r, ov_nxt, ol_r, ol_nxt;
  logic [7:0]                   ot_r, ot_nxt, cur_byte;
  logic                         is_data, wr_go, allowed_ld;
  logic [15:0]                  wr_word;
  logic                         p_we, d_we;
  logic [mbrtu_pkg::PA_AW-1:0]  p_wa;
  logic [mbrtu_pkg::DA_AW-1:0]  d_wa;
  logic [15:0]                  p_wd, d_wd;
  logic [8:0]                   fs_base;

  assign idle          = (st_r == S_IDLE);
  assign out_valid     = ov_r;
  assign out_tx_byte   = ot_r;
  assign out_last_byte = ol_r;
  assign drive_off     = wa_r - WA_W'(mbrtu_pkg::DRIVE_BASE);
  assign is_data       = (kind_r == mbrtu_pkg::JOB_READ) &&
                         (idx_r >= mbrtu_pkg::RPL_W'(3)) && (idx_r < len_r);
  assign fs_base       = {k_r, 1'b0} + ((st_r == S_WR_B) ? 9'd8 : 9'd7);
  assign fs_raddr      = fs_base[mbrtu_pkg::FS_AW-1:0];
  assign wr_word       = (st_r == S_WR_ONE) ? {b4_r, b5_r} : {hi_r, fs_rdata};
  assign wr_go         = (st_r == S_WR_ONE) || (st_r == S_WR_C);

  // Load-time decode of the queued job.
  always_comb begin
    logic [mbrtu_pkg::CNT_W-1:0] rest;
    rest       = job.n - mbrtu_pkg::CNT_W'(9);
    avail      = (job.n >= mbrtu_pkg::CNT_W'(9)) ? mbrtu_pkg::WC_W'(rest >> 1) : '0;
    allowed_ld = (job.addr <= mbrtu_pkg::WRITE_LIMIT);
    if (job.kind == mbrtu_pkg::JOB_READ) begin
      words_ld = (job.b5 > mbrtu_pkg::WC_W'(mbrtu_pkg::MAX_READ_WORDS)) ?
                 mbrtu_pkg::WC_W'(mbrtu_pkg::MAX_READ_WORDS) : job.b5;
    end else begin
      words_ld = (job.b5 > avail) ? avail : job.b5;
    end
  end

  // Current reply byte.
  always_comb begin
    cur_byte = 8'h00;
    if (idx_r == '0) begin
      cur_byte = cfg.dev_addr;
    end else if (idx_r == mbrtu_pkg::RPL_W'(1)) begin
      cur_byte = fn_r;
    end else if (idx_r == len_r) begin
      cur_byte = crc_r[7:0];
    end else if (idx_r == len_r + 1'b1) begin
      cur_byte = crc_r[15:8];
    end else if (kind_r == mbrtu_pkg::JOB_READ) begin
      if (idx_r == mbrtu_pkg::RPL_W'(2)) begin
        cur_byte = {words_r[6:0], 1'b0};
      end else begin
        cur_byte = idx_r[0] ? word_r[15:8] : word_r[7:0];
      end
    end else begin
      case (idx_r)
        mbrtu_pkg::RPL_W'(2): cur_byte = addr_r[15:8];
        mbrtu_pkg::RPL_W'(3): cur_byte = addr_r[7:0];
        mbrtu_pkg::RPL_W'(4): cur_byte = allowed_r ? b4_r : 8'hFF;
        default:              cur_byte = allowed_r ? b5_r : 8'hFF;
      endcase
    end
  end

  // Table write ports: clearing pass or word write.
  always_comb begin
    p_we = 1'b0;
    d_we = 1'b0;
    p_wa = wa_r[mbrtu_pkg::PA_AW-1:0];
    d_wa = drive_off[mbrtu_pkg::DA_AW-1:0];
    p_wd = wr_word;
    d_wd = wr_word;
    if (st_r == S_CLEAR) begin
      p_we = ({1'b0, clr_r} < (mbrtu_pkg::CLR_W + 1)'(mbrtu_pkg::PARAM_DEPTH));
      d_we = ({1'b0, clr_r} < (mbrtu_pkg::CLR_W + 1)'(mbrtu_pkg::DRIVE_DEPTH));
      p_wa = clr_r[mbrtu_pkg::PA_AW-1:0];
      d_wa = clr_r[mbrtu_pkg::DA_AW-1:0];
      p_wd = 16'h0000;
      d_wd = 16'h0000;
    end else if (wr_go) begin
      if (addr_r < mbrtu_pkg::PARAM_LIMIT) begin
        p_we = (wa_r < WA_W'(mbrtu_pkg::PARAM_DEPTH));
      end else if (addr_r >= mbrtu_pkg::DRIVE_BASE) begin
        d_we = (wa_r >= WA_W'(mbrtu_pkg::DRIVE_BASE)) &&
               (drive_off < WA_W'(mbrtu_pkg::DRIVE_DEPTH));
      end
    end
  end

  always_comb begin
    st_nxt      = st_r;
    clr_nxt     = clr_r;
    kind_nxt    = kind_r;
    fn_nxt      = fn_r;
    b4_nxt      = b4_r;
    b5_nxt      = b5_r;
    hi_nxt      = hi_r;
    addr_nxt    = addr_r;
    crc_nxt     = crc_r;
    word_nxt    = word_r;
    wa_nxt      = wa_r;
    k_nxt       = k_r;
    words_nxt   = words_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    allowed_nxt = allowed_r;
    have_nxt    = have_r;
    selp_nxt    = selp_r;
    seld_nxt    = seld_r;
    ov_nxt      = ov_r && !out_ready;
    ot_nxt      = ot_r;
    ol_nxt      = ol_r;
    job_pop     = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == mbrtu_pkg::CLR_W'(mbrtu_pkg::CLR_DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          kind_nxt    = job.kind;
          fn_nxt      = job.fn;
          addr_nxt    = job.addr;
          b4_nxt      = job.b4;
          b5_nxt      = job.b5;
          wa_nxt      = {1'b0, job.addr};
          k_nxt       = '0;
          idx_nxt     = '0;
          crc_nxt     = 16'hFFFF;
          have_nxt    = 1'b0;
          words_nxt   = words_ld;
          allowed_nxt = allowed_ld;
          len_nxt     = (job.kind == mbrtu_pkg::JOB_READ) ?
                        mbrtu_pkg::RPL_W'(3) + mbrtu_pkg::RPL_W'({words_ld, 1'b0}) :
                        mbrtu_pkg::RPL_W'(6);
          st_nxt      = S_EMIT;
          if (job.kind == mbrtu_pkg::JOB_WR_ONE && allowed_ld) begin
            st_nxt = S_WR_ONE;
          end else if (job.kind == mbrtu_pkg::JOB_WR_MULTI && allowed_ld &&
                       job.b5 < mbrtu_pkg::MULTI_LIMIT && words_ld != '0) begin
            st_nxt = S_WR_A;
          end
        end
      end
      S_WR_ONE: st_nxt = S_EMIT;
      S_WR_A:   st_nxt = S_WR_B;
      S_WR_B: begin
        hi_nxt = fs_rdata;
        st_nxt = S_WR_C;
      end
      S_WR_C: begin
        if (k_r + 1'b1 == words_r) begin
          k_nxt  = '0;
          wa_nxt = {1'b0, addr_r};
          st_nxt = S_EMIT;
        end else begin
          k_nxt  = k_r + 1'b1;
          wa_nxt = wa_r + 1'b1;
          st_nxt = S_WR_A;
        end
      end
      S_FETCH: begin
        selp_nxt = cfg.read_en && (wa_r < WA_W'(mbrtu_pkg::PARAM_LIMIT)) &&
                   (wa_r < WA_W'(mbrtu_pkg::PARAM_DEPTH));
        seld_nxt = cfg.read_en && (wa_r >= WA_W'(mbrtu_pkg::DRIVE_BASE)) &&
                   (drive_off < WA_W'(mbrtu_pkg::DRIVE_DEPTH));
        st_nxt   = S_WAIT;
      end
      S_WAIT: begin
        word_nxt = selp_r ? param_q : (seld_r ? drive_q : 16'h0000);
        have_nxt = 1'b1;
        st_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (is_data && idx_r[0] && !have_r) begin
          st_nxt = S_FETCH;
        end else if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          ot_nxt  = cur_byte;
          ol_nxt  = (idx_r == len_r + 1'b1);
          idx_nxt = idx_r + 1'b1;
          if (idx_r < len_r) begin
            crc_nxt = mbrtu_pkg::crc_upd(crc_r, cur_byte);
          end
          if (is_data && !idx_r[0]) begin
            have_nxt = 1'b0;
            wa_nxt   = wa_r + 1'b1;
          end
          if (idx_r == len_r + 1'b1) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    fn_r      <= fn_nxt;
    b4_r      <= b4_nxt;
    b5_r      <= b5_nxt;
    hi_r      <= hi_nxt;
    addr_r    <= addr_nxt;
    crc_r     <= crc_nxt;
    word_r    <= word_nxt;
    wa_r      <= wa_nxt;
    k_r       <= k_nxt;
    words_r   <= words_nxt;
    idx_r     <= idx_nxt;
    len_r     <= len_nxt;
    allowed_r <= allowed_nxt;
    have_r    <= have_nxt;
    selp_r    <= selp_nxt;
    seld_r    <= seld_nxt;
    ot_r      <= ot_nxt;
    ol_r      <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      param_mem[p_wa] <= p_wd;
    end
    param_q <= param_mem[wa_r[mbrtu_pkg::PA_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      drive_mem[d_wa] <= d_wd;
    end
    drive_q <= drive_mem[drive_off[mbrtu_pkg::DA_AW-1:0]];
  end

endmodule

/* sv/modbus_rtu_slave_register_server.sv */
// Top level of the Modbus RTU slave register server.
//
//   Channel  Direction  Payload                    Transaction
//   in_ch    sink       opcode, rx_byte            one received byte or one millisecond tick
//   out_ch   source     tx_byte, last_byte         one reply byte
//   cfg_ch   sink       index, data                one configuration register write
//
// After reset the tables are swept to zero, one word per cycle, and no input transaction is
// taken meanwhile. The front part handles each input transaction; the tick that closes a valid
// frame queues a job and input waits until the back part is done. The back part takes the job,
// runs S_WR_ONE for a function 6 write or S_WR_A to S_WR_C per word written by function 16,
// then emits one reply byte per cycle while the sink is ready, with S_FETCH and S_WAIT before
// each word read. A stalled sink stalls only the back part; configuration is taken every cycle.
module modbus_rtu_slave_register_server (
  input  logic        clk,
  input  logic        rst_n,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch,
  mbrtu_cfg_if.sink   cfg_ch
);

  mbrtu_pkg::cfg_t                cfg_r, cfg_nxt;
  mbrtu_pkg::job_t                push_job, head_job;
  logic                           push, q_nonempty, job_pop, back_idle, can_take;
  logic [mbrtu_pkg::FS_AW-1:0]    fs_raddr;
  logic [7:0]                     fs_rdata;

  // Configuration registers; an index beyond the list is ignored.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mbrtu_pkg::CFG_DEV_ADDR: cfg_nxt.dev_addr = cfg_ch.data;
        mbrtu_pkg::CFG_SILENCE:  cfg_nxt.silence  = cfg_ch.data;
        mbrtu_pkg::CFG_READ_EN:  cfg_nxt.read_en  = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dev_addr: 8'd1, silence: 8'd5, read_en: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The frame store is shared with the back part, so input waits for a served frame to finish.
  assign can_take = back_idle && !q_nonempty;

  mbrtu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .can_take   (can_take),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .in_rx_byte (in_ch.rx_byte),
    .push       (push),
    .push_job   (push_job),
    .fs_raddr   (fs_raddr),
    .fs_rdata   (fs_rdata)
  );

  mbrtu_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (job_pop),
    .nonempty (q_nonempty),
    .head     (head_job)
  );

  mbrtu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job_valid     (q_nonempty),
    .job           (head_job),
    .job_pop       (job_pop),
    .idle          (back_idle),
    .fs_raddr      (fs_raddr),
    .fs_rdata      (fs_rdata),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_tx_byte   (out_ch.tx_byte),
    .out_last_byte (out_ch.last_byte)
  );

endmodule

/* sv/mbrtu_checker.sv */
// Port-level checker for the Modbus RTU slave, with its bind statement.
module mbrtu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("reply byte withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tx_byte) && $stable(out_last_byte))
    else $error("reply byte changed while stalled");

  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during table clearing");

  a_byte_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == mbrtu_pkg::OP_BYTE) && !out_valid |=> !out_valid)
    else $error("reply started by a received byte");

endmodule

bind modbus_rtu_slave_register_server mbrtu_checker u_mbrtu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_opcode     (in_ch.opcode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_tx_byte   (out_ch.tx_byte),
  .out_last_byte (out_ch.last_byte)
);
